// File: rtl/core/rcrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, register indexes and codes of the rotated clip rectangle stack.
package rcrs_pkg;

   // Fixed field widths of the channels and the register port
   localparam int POS_WIDTH        = 16;
   localparam int SCISSOR_XY_WIDTH = 16;
   localparam int SCISSOR_WH_WIDTH = 15;
   localparam int CFG_DIM_WIDTH    = 14;
   localparam int ROT_WIDTH        = 2;
   localparam int STATUS_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 14;

   // Width of a rectangle after rotation into window space, before clipping.
   // It holds every sum that the mapping can form from the fields above.
   localparam int MAP_WIDTH = 20;

   // Command kinds
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PUSH_FULL = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_X      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_Y      = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATION      = 3'd6;

   // Rotation codes in quarter turns
   localparam logic [ROT_WIDTH-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_WIDTH-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_WIDTH-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_WIDTH-1:0] ROT_270 = 2'd3;

   // Register values after reset
   localparam logic [CFG_DIM_WIDTH-1:0] WINDOW_WIDTH_RESET  = 14'd1920;
   localparam logic [CFG_DIM_WIDTH-1:0] WINDOW_HEIGHT_RESET = 14'd1080;
   localparam logic [CFG_DIM_WIDTH-1:0] SCREEN_WIDTH_RESET  = 14'd1920;
   localparam logic [CFG_DIM_WIDTH-1:0] SCREEN_HEIGHT_RESET = 14'd1080;

   typedef struct packed {
      logic                        kind;
      logic signed [POS_WIDTH-1:0] pos_x;
      logic signed [POS_WIDTH-1:0] pos_y;
      logic signed [POS_WIDTH-1:0] size_w;
      logic signed [POS_WIDTH-1:0] size_h;
   } req_payload_type;

   typedef struct packed {
      logic signed [SCISSOR_XY_WIDTH-1:0] scissor_x;
      logic signed [SCISSOR_XY_WIDTH-1:0] scissor_y;
      logic        [SCISSOR_WH_WIDTH-1:0] scissor_w;
      logic        [SCISSOR_WH_WIDTH-1:0] scissor_h;
      logic        [STATUS_WIDTH-1:0]     status;
   } rsp_payload_type;

   typedef struct packed {
      logic [CFG_DIM_WIDTH-1:0] window_width;
      logic [CFG_DIM_WIDTH-1:0] window_height;
      logic [CFG_DIM_WIDTH-1:0] screen_width;
      logic [CFG_DIM_WIDTH-1:0] screen_height;
      logic [CFG_DIM_WIDTH-1:0] offset_x;
      logic [CFG_DIM_WIDTH-1:0] offset_y;
      logic [ROT_WIDTH-1:0]     rotation;
   } cfg_type;

   typedef struct packed {
      logic signed [MAP_WIDTH-1:0] x;
      logic signed [MAP_WIDTH-1:0] y;
      logic signed [MAP_WIDTH-1:0] w;
      logic signed [MAP_WIDTH-1:0] h;
   } map_rect_type;

endpackage

// File: rtl/core/rcrs_map.sv
`timescale 1ns / 1ps
// Mapping of a screen-space rectangle into window space by rotation and offsets.
module rcrs_map
   import rcrs_pkg::*;
(
   input  req_payload_type req,
   input  cfg_type         cfg,
   output map_rect_type    rect
);

   logic signed [MAP_WIDTH-1:0] px;
   logic signed [MAP_WIDTH-1:0] py;
   logic signed [MAP_WIDTH-1:0] sw;
   logic signed [MAP_WIDTH-1:0] sh;
   logic signed [MAP_WIDTH-1:0] ww;
   logic signed [MAP_WIDTH-1:0] wh;
   logic signed [MAP_WIDTH-1:0] ox;
   logic signed [MAP_WIDTH-1:0] oy;
   logic signed [MAP_WIDTH-1:0] scw;
   logic signed [MAP_WIDTH-1:0] sch;

   // Widen the fields; the registers are unsigned and zero extend.
   always_comb begin
      px  = MAP_WIDTH'(req.pos_x);
      py  = MAP_WIDTH'(req.pos_y);
      ww  = MAP_WIDTH'(cfg.window_width);
      wh  = MAP_WIDTH'(cfg.window_height);
      ox  = MAP_WIDTH'(cfg.offset_x);
      oy  = MAP_WIDTH'(cfg.offset_y);
      scw = MAP_WIDTH'(cfg.screen_width);
      sch = MAP_WIDTH'(cfg.screen_height);
   end

   // A zero size reaches to the far screen edge.
   always_comb begin
      sw = (req.size_w == '0) ? (scw - px) : MAP_WIDTH'(req.size_w);
      sh = (req.size_h == '0) ? (sch - py) : MAP_WIDTH'(req.size_h);
   end

   // Quarter-turn rotation into window space.
   always_comb begin
      unique case (cfg.rotation)
         ROT_0: begin
            rect.x = ox + px;
            rect.y = oy + py;
            rect.w = sw;
            rect.h = sh;
         end
         ROT_90: begin
            rect.x = ww - oy - py - sh;
            rect.y = ox + px;
            rect.w = sh;
            rect.h = sw;
         end
         ROT_180: begin
            rect.x = ww - ox - px - sw;
            rect.y = wh - oy - py - sh;
            rect.w = sw;
            rect.h = sh;
         end
         ROT_270: begin
            rect.x = oy + py;
            rect.y = wh - ox - px - sw;
            rect.w = sh;
            rect.h = sw;
         end
      endcase
   end

endmodule

// File: rtl/core/rcrs_stack_mem.sv
`timescale 1ns / 1ps
// Rectangle stack memory with one write port and one registered read port.
module rcrs_stack_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 62,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write and read in the same clocked block; the read data is held until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rcrs_clip.sv
`timescale 1ns / 1ps
// Two-stage clip of a mapped rectangle against the stack top, with saturation.
module rcrs_clip
   import rcrs_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          has_top,
   input  map_rect_type                  rect,
   input  logic signed [COORD_WIDTH-1:0] top_x,
   input  logic signed [COORD_WIDTH-1:0] top_y,
   input  logic        [COORD_WIDTH-2:0] top_w,
   input  logic        [COORD_WIDTH-2:0] top_h,
   output logic signed [COORD_WIDTH-1:0] clip_x,
   output logic signed [COORD_WIDTH-1:0] clip_y,
   output logic        [COORD_WIDTH-2:0] clip_w,
   output logic        [COORD_WIDTH-2:0] clip_h
);

   localparam int EXT_WIDTH = ((COORD_WIDTH > MAP_WIDTH) ? COORD_WIDTH : MAP_WIDTH) + 3;
   localparam logic signed [EXT_WIDTH-1:0] SAT_MAX =
      {{(EXT_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [EXT_WIDTH-1:0] SAT_MIN = ~SAT_MAX;

   logic signed [EXT_WIDTH-1:0] bx, by, tx, ty, tw, th;
   logic signed [EXT_WIDTH-1:0] near_x_in, near_y_in, far_x_in, far_y_in;
   logic signed [EXT_WIDTH-1:0] near_x_ff, near_y_ff, far_x_ff, far_y_ff;
   logic signed [EXT_WIDTH-1:0] size_w_ff, size_h_ff;
   logic                        has_top_ff;
   logic signed [EXT_WIDTH-1:0] span_w, span_h, cut_w, cut_h;
   logic signed [EXT_WIDTH-1:0] sat_x, sat_y, sat_w, sat_h;

   // First stage: pull the corner inside the top and form the top's far edges.
   always_comb begin
      bx = EXT_WIDTH'(rect.x);
      by = EXT_WIDTH'(rect.y);
      tx = EXT_WIDTH'(top_x);
      ty = EXT_WIDTH'(top_y);
      tw = EXT_WIDTH'(top_w);
      th = EXT_WIDTH'(top_h);
      near_x_in = (has_top && (tx > bx)) ? tx : bx;
      near_y_in = (has_top && (ty > by)) ? ty : by;
      far_x_in  = tx + tw;
      far_y_in  = ty + th;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         near_x_ff  <= near_x_in;
         near_y_ff  <= near_y_in;
         far_x_ff   <= far_x_in;
         far_y_ff   <= far_y_in;
         size_w_ff  <= EXT_WIDTH'(rect.w);
         size_h_ff  <= EXT_WIDTH'(rect.h);
         has_top_ff <= has_top;
      end
   end

   // Second stage: cut the size back to the top's far edge; the size is never grown.
   always_comb begin
      span_w = far_x_ff - near_x_ff;
      span_h = far_y_ff - near_y_ff;
      cut_w  = (has_top_ff && (span_w < size_w_ff)) ? span_w : size_w_ff;
      cut_h  = (has_top_ff && (span_h < size_h_ff)) ? span_h : size_h_ff;
   end

   // Saturate the corner to the signed coordinate range and the size to zero and above.
   always_comb begin
      priority if (near_x_ff > SAT_MAX) sat_x = SAT_MAX;
      else if (near_x_ff < SAT_MIN)     sat_x = SAT_MIN;
      else                              sat_x = near_x_ff;

      priority if (near_y_ff > SAT_MAX) sat_y = SAT_MAX;
      else if (near_y_ff < SAT_MIN)     sat_y = SAT_MIN;
      else                              sat_y = near_y_ff;

      priority if (cut_w > SAT_MAX) sat_w = SAT_MAX;
      else if (cut_w < 0)           sat_w = '0;
      else                          sat_w = cut_w;

      priority if (cut_h > SAT_MAX) sat_h = SAT_MAX;
      else if (cut_h < 0)           sat_h = '0;
      else                          sat_h = cut_h;
   end

   assign clip_x = sat_x[COORD_WIDTH-1:0];
   assign clip_y = sat_y[COORD_WIDTH-1:0];
   assign clip_w = sat_w[COORD_WIDTH-2:0];
   assign clip_h = sat_h[COORD_WIDTH-2:0];

endmodule

// File: rtl/core/rotated_clip_rect_stack.sv
`timescale 1ns / 1ps
// Top level of the rotated clip rectangle stack: registers, control and result register.
//
// The req channel takes one command beat: a push of a screen-space rectangle or a pop.
// The rsp channel gives exactly one beat for every command: the scissor rectangle in
// window space and a status (ok, pop on an empty stack, push onto a full stack).
// The csr port writes the window and screen sizes, the offsets and the rotation; the
// user must write it only while no command is in flight; the block does not enforce this.
// After acceptance a command passes the clip state and the done state, where its result
// is loaded into the result register. The stack top is read from the stack memory in
// the accept cycle, and two clip stages follow before the write-back, so the next
// command is taken only once the previous one has updated the stack.
// The result sits in an output register; a stalled receiver holds it there, and a
// further command is accepted and processed meanwhile, waiting in its last stage until
// the register is free.
// Reset (synchronous) empties the stack and loads the default registers; the stack
// memory itself is not cleared, as only entries below the fill count are ever read.
module rotated_clip_rect_stack
   import rcrs_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_WIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int ENTRY_WIDTH = 4 * COORD_WIDTH - 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLIP,
      ST_DONE
   } state_type;

   state_type              state_ff;
   cfg_type                cfg_ff;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [CNT_WIDTH-1:0]   count_m1, count_m2;
   logic                   pop_ff, full_ff, empty_ff, top_valid_ff;
   map_rect_type           map_rect, map_ff;
   rsp_payload_type        rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   req_accept, out_free, load_rsp;
   logic                   cmd_pop, cmd_full, cmd_empty, cmd_top;
   logic                   rd_en, wr_en;
   logic [ADDR_WIDTH-1:0]  rd_addr, wr_addr;
   logic [ENTRY_WIDTH-1:0] rd_data, wr_data;
   logic signed [COORD_WIDTH-1:0] top_x, top_y, clip_x, clip_y;
   logic        [COORD_WIDTH-2:0] top_w, top_h, clip_w, clip_h;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_width  <= WINDOW_WIDTH_RESET;
         cfg_ff.window_height <= WINDOW_HEIGHT_RESET;
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
         cfg_ff.offset_x      <= '0;
         cfg_ff.offset_y      <= '0;
         cfg_ff.rotation      <= ROT_0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_WIDTH:  cfg_ff.window_width  <= csr_wr_data;
            CSR_WINDOW_HEIGHT: cfg_ff.window_height <= csr_wr_data;
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wr_data;
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wr_data;
            CSR_OFFSET_X:      cfg_ff.offset_x      <= csr_wr_data;
            CSR_OFFSET_Y:      cfg_ff.offset_y      <= csr_wr_data;
            CSR_ROTATION:      cfg_ff.rotation      <= csr_wr_data[ROT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake and command decode
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_rsp   = (state_ff == ST_DONE) && out_free;

   always_comb begin
      count_m1  = count_ff - CNT_WIDTH'(1);
      count_m2  = count_ff - CNT_WIDTH'(2);
      cmd_pop   = (req_payload.kind == KIND_POP);
      cmd_full  = (count_ff == CNT_WIDTH'(STACK_DEPTH));
      cmd_empty = (count_ff == '0);
      // A pop shows the entry under the top; a push clips against the top.
      cmd_top   = cmd_pop ? (count_ff > CNT_WIDTH'(1)) : !cmd_empty;
   end

   rcrs_map u_map (
      .req  (req_payload),
      .cfg  (cfg_ff),
      .rect (map_rect)
   );

   // Stack memory: the top is read in the accept cycle, the new top written at the end.
   assign rd_en   = req_accept && cmd_top;
   assign rd_addr = cmd_pop ? count_m2[ADDR_WIDTH-1:0] : count_m1[ADDR_WIDTH-1:0];
   assign wr_en   = load_rsp && !pop_ff && !full_ff;
   assign wr_addr = count_ff[ADDR_WIDTH-1:0];
   assign wr_data = {clip_x, clip_y, clip_w, clip_h};

   rcrs_stack_mem #(
      .DEPTH      (STACK_DEPTH),
      .DATA_WIDTH (ENTRY_WIDTH)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign top_x = rd_data[4*COORD_WIDTH-3:3*COORD_WIDTH-2];
   assign top_y = rd_data[3*COORD_WIDTH-3:2*COORD_WIDTH-2];
   assign top_w = rd_data[2*COORD_WIDTH-3:COORD_WIDTH-1];
   assign top_h = rd_data[COORD_WIDTH-2:0];

   rcrs_clip #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_clip (
      .clock   (clock),
      .load    (state_ff == ST_CLIP),
      .has_top (top_valid_ff),
      .rect    (map_ff),
      .top_x   (top_x),
      .top_y   (top_y),
      .top_w   (top_w),
      .top_h   (top_h),
      .clip_x  (clip_x),
      .clip_y  (clip_y),
      .clip_w  (clip_w),
      .clip_h  (clip_h)
   );

   // Next fill count and result beat
   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      rsp_in.status = STATUS_OK;
      priority if (!pop_ff && !full_ff) begin
         count_in         = count_ff + CNT_WIDTH'(1);
         rsp_in.scissor_x = SCISSOR_XY_WIDTH'(clip_x);
         rsp_in.scissor_y = SCISSOR_XY_WIDTH'(clip_y);
         rsp_in.scissor_w = SCISSOR_WH_WIDTH'(clip_w);
         rsp_in.scissor_h = SCISSOR_WH_WIDTH'(clip_h);
      end else if (!pop_ff) begin
         rsp_in.scissor_x = SCISSOR_XY_WIDTH'(top_x);
         rsp_in.scissor_y = SCISSOR_XY_WIDTH'(top_y);
         rsp_in.scissor_w = SCISSOR_WH_WIDTH'(top_w);
         rsp_in.scissor_h = SCISSOR_WH_WIDTH'(top_h);
         rsp_in.status    = STATUS_PUSH_FULL;
      end else if (empty_ff) begin
         rsp_in.status = STATUS_POP_EMPTY;
      end else begin
         count_in = count_m1;
         if (top_valid_ff) begin
            rsp_in.scissor_x = SCISSOR_XY_WIDTH'(top_x);
            rsp_in.scissor_y = SCISSOR_XY_WIDTH'(top_y);
            rsp_in.scissor_w = SCISSOR_WH_WIDTH'(top_w);
            rsp_in.scissor_h = SCISSOR_WH_WIDTH'(top_h);
         end
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   // Sequencer: accept and read, clip, then write back and load the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff     <= ST_CLIP;
                  pop_ff       <= cmd_pop;
                  full_ff      <= !cmd_pop && cmd_full;
                  empty_ff     <= cmd_pop && cmd_empty;
                  top_valid_ff <= cmd_top;
                  map_ff       <= map_rect;
               end
            end
            ST_CLIP: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
                  count_ff <= count_in;
                  rsp_ff   <= rsp_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The fill count never passes the stack depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(STACK_DEPTH))
      else $error("stack fill count beyond depth");

   // A full-stack status is only shown while the stack is indeed full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_PUSH_FULL)) |->
         (count_ff == CNT_WIDTH'(STACK_DEPTH)))
      else $error("full status with a stack that is not full");

   // An empty-stack status is only shown while the stack is empty.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_POP_EMPTY)) |-> (count_ff == '0))
      else $error("empty status with a stack that is not empty");

   // The fill count only moves together with a new result beat.
   a_count_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(load_rsp))
      else $error("fill count changed without a result");

endmodule
